@@ src/oriented_box_corner_generator_assert.svh @@
// Assertion macros shared by the oriented box corner generator modules.
`ifndef ORIENTED_BOX_CORNER_GENERATOR_ASSERT_SVH
`define ORIENTED_BOX_CORNER_GENERATOR_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked on i_clk, off during reset.
`define OBCG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on i_clk, off during reset.
`define OBCG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OBCG_ASSERT_IMP(lbl, ante, cons, msg)
`define OBCG_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/obcg_pkg.sv @@
// Shared constants, tables and types of the oriented box corner generator.
package obcg_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int CORDIC_STEPS    = 30;
    localparam int Z_W             = 34;
    localparam int XY_W            = 32;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [Z_W-1:0]  Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [Z_W-1:0]  Q30_PI      = 34'sd3373259426;

    // Arctangent of 2^-i in Q30 radians.
    localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
        32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
        32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535,
        32'd32767, 32'd16383, 32'd8191, 32'd4095, 32'd2047,
        32'd1023, 32'd511, 32'd255, 32'd127, 32'd63,
        32'd31, 32'd15, 32'd8, 32'd4, 32'd2
    };

    // One CORDIC vector: cosine, sine and residual angle.
    typedef struct packed {
        logic [XY_W-1:0] x;
        logic [XY_W-1:0] y;
        logic [Z_W-1:0]  z;
    } t_cvec;

endpackage

@@ src/obcg_if.sv @@
// Handshake interfaces for box transactions and corner transactions.
interface obcg_box_if #(
    parameter int CW = 32,
    parameter int AW = 16
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic signed [CW-1:0] center_z;
    logic signed [AW-1:0] angle_x;
    logic signed [AW-1:0] angle_y;
    logic signed [AW-1:0] angle_z;
    logic [CW-2:0]        size_x;
    logic [CW-2:0]        size_y;
    logic [CW-2:0]        size_z;

    modport source (output valid, center_x, center_y, center_z, angle_x, angle_y, angle_z,
                    size_x, size_y, size_z, input ready);
    modport sink (input valid, center_x, center_y, center_z, angle_x, angle_y, angle_z,
                  size_x, size_y, size_z, output ready);
endinterface

interface obcg_corner_if #(
    parameter int CW = 32
);
    logic                 valid;
    logic                 ready;
    logic [2:0]           corner_index;
    logic signed [CW-1:0] corner_x;
    logic signed [CW-1:0] corner_y;
    logic signed [CW-1:0] corner_z;
    logic                 last_corner;

    modport source (output valid, corner_index, corner_x, corner_y, corner_z, last_corner,
                    input ready);
    modport sink (input valid, corner_index, corner_x, corner_y, corner_z, last_corner,
                  output ready);
endinterface

@@ src/obcg_cordic_cell.sv @@
// One CORDIC iteration for the three angles of a box, with the box data riding along.
module obcg_cordic_cell import obcg_pkg::*; #(
    parameter int STEP = 0,
    parameter int PW   = 96
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_v,
    input  t_cvec [2:0]   i_vec,
    input  logic [PW-1:0] i_pay,
    output logic          o_v,
    output t_cvec [2:0]   o_vec,
    output logic [PW-1:0] o_pay
);

    localparam logic signed [Z_W-1:0] ATAN = $signed({2'b00, ATAN_Q30[STEP]});

    logic          r_v;
    t_cvec [2:0]   r_vec;
    logic [PW-1:0] r_pay;
    t_cvec [2:0]   n_vec;

    // Micro-rotation toward zero residual angle, old x and y on both sides.
    always_comb begin
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        for (int a = 0; a < 3; a++) begin
            x = $signed(i_vec[a].x);
            y = $signed(i_vec[a].y);
            z = $signed(i_vec[a].z);
            if (!z[Z_W-1]) begin
                n_vec[a].x = x - (y >>> STEP);
                n_vec[a].y = y + (x >>> STEP);
                n_vec[a].z = z - ATAN;
            end else begin
                n_vec[a].x = x + (y >>> STEP);
                n_vec[a].y = y - (x >>> STEP);
                n_vec[a].z = z + ATAN;
            end
        end
    end

    // Hand the vector to the next cell whenever the row advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_adv) begin
            r_v <= i_v;
        end
        if (i_adv) begin
            r_vec <= n_vec;
            r_pay <= i_pay;
        end
    end

    assign o_v   = r_v;
    assign o_vec = r_vec;
    assign o_pay = r_pay;

endmodule

@@ src/obcg_corner_pipe.sv @@
// Corner sequencer, three-axis rotation pipeline and output skid stage.
`include "oriented_box_corner_generator_assert.svh"
module obcg_corner_pipe import obcg_pkg::*; #(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int PW = 3 * CW + 3 * (CW - 1) + 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cell_v,
    input  t_cvec [2:0]   i_cell_vec,
    input  logic [PW-1:0] i_cell_pay,
    output logic          o_chain_adv,
    obcg_corner_if.source o_corner
);

    localparam int T    = ((62 - CW) > 30) ? 30 : (62 - CW);
    localparam int TSH  = 30 - T;
    localparam int TW   = T + 2;
    localparam int RW   = CW + 2;
    localparam int PRW  = TW + RW;
    localparam int HALF = 1 << (T - 1);
    localparam int THALF = (TSH > 0) ? (1 << ((TSH > 0) ? TSH - 1 : 0)) : 0;

    // Round a sum of products from trig fraction bits back to offset units.
    function automatic logic signed [RW-1:0] rnd(input logic signed [PRW:0] s);
        logic signed [PRW:0] t;
        t = s + $signed((PRW + 1)'(HALF));
        return RW'(t >>> T);
    endfunction

    // Round a Q30 CORDIC output to the trig precision, negated when flipped.
    function automatic logic signed [TW-1:0] trig(input logic [XY_W-1:0] v, input logic flip);
        logic signed [XY_W:0] t;
        t = $signed({v[XY_W-1], v});
        if (flip) begin
            t = -t;
        end
        t = t + $signed((XY_W + 1)'(THALF));
        return TW'(t >>> TSH);
    endfunction

    // Add the halved offset to the center and clamp to the coordinate range.
    function automatic logic [CW-1:0] fin(input logic [CW-1:0] cen,
                                          input logic signed [RW-1:0] off);
        logic signed [RW-1:0] h;
        logic signed [RW:0]   s;
        h = off + $signed(RW'(1));
        h = h >>> 1;
        s = $signed({{(RW + 1 - CW){cen[CW-1]}}, cen}) + $signed({h[RW-1], h});
        if (s[RW:CW-1] != {(RW - CW + 2){1'b0}} && s[RW:CW-1] != {(RW - CW + 2){1'b1}}) begin
            return s[RW] ? {1'b1, {(CW - 1){1'b0}}} : {1'b0, {(CW - 1){1'b1}}};
        end
        return s[CW-1:0];
    endfunction

    logic en;
    logic take;

    // Box held while its eight corners are issued.
    logic                 r_busy;
    logic [2:0]           r_cnt;
    logic signed [TW-1:0] r_cos [3];
    logic signed [TW-1:0] r_sin [3];
    logic [CW-2:0]        r_size [3];
    logic [CW-1:0]        r_cen [3];

    // Rotation pipeline stages.
    logic                  r_a_v, r_b_v, r_c_v, r_d_v, r_e_v, r_f_v;
    logic [2:0]            r_a_idx, r_b_idx, r_c_idx, r_d_idx, r_e_idx, r_f_idx;
    logic signed [PRW-1:0] r_a_p [4];
    logic signed [PRW-1:0] r_c_p [4];
    logic signed [PRW-1:0] r_e_p [4];
    logic signed [RW-1:0]  r_a_x0, r_b_x0;
    logic signed [RW-1:0]  r_b_y1, r_b_z1, r_c_y1, r_d_y1;
    logic signed [RW-1:0]  r_d_x2, r_d_z2, r_e_z2;
    logic signed [RW-1:0]  r_f_x3, r_f_y3, r_f_z3;
    logic signed [TW-1:0]  r_a_cy, r_a_sy, r_b_cy, r_b_sy;
    logic signed [TW-1:0]  r_a_cz, r_a_sz, r_b_cz, r_b_sz, r_c_cz, r_c_sz, r_d_cz, r_d_sz;
    logic [CW-1:0]         r_a_cen [3];
    logic [CW-1:0]         r_b_cen [3];
    logic [CW-1:0]         r_c_cen [3];
    logic [CW-1:0]         r_d_cen [3];
    logic [CW-1:0]         r_e_cen [3];
    logic [CW-1:0]         r_f_cen [3];

    // Output register and skid stage.
    logic          r_out_v, r_sk_v;
    logic [2:0]    r_out_idx, r_sk_idx;
    logic [CW-1:0] r_out_x, r_out_y, r_out_z, r_sk_x, r_sk_y, r_sk_z;
    logic [CW-1:0] n_x, n_y, n_z;

    logic signed [RW-1:0] off_x, off_y, off_z;
    logic signed [RW-1:0] ext_x, ext_y, ext_z;

    // The pipeline moves while the skid stage is empty.
    assign en          = !r_sk_v;
    assign take        = en && i_cell_v && (!r_busy || r_cnt == 3'd7);
    assign o_chain_adv = en && (!i_cell_v || take);

    // Corner offsets: x positive on corners 1,2,5,6, y on 2,3,6,7, z on 4..7.
    assign ext_x = $signed({3'b000, r_size[0]});
    assign ext_y = $signed({3'b000, r_size[1]});
    assign ext_z = $signed({3'b000, r_size[2]});
    assign off_x = (r_cnt[0] ^ r_cnt[1]) ? ext_x : -ext_x;
    assign off_y = r_cnt[1] ? ext_y : -ext_y;
    assign off_z = r_cnt[2] ? ext_z : -ext_z;

    // Sequencer: load a box, then issue corners 0 to 7.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
        end else if (en) begin
            if (take) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                end
            end
        end
        if (take) begin
            for (int a = 0; a < 3; a++) begin
                r_cos[a]  <= trig(i_cell_vec[a].x, i_cell_pay[PW-3+a]);
                r_sin[a]  <= trig(i_cell_vec[a].y, i_cell_pay[PW-3+a]);
                r_cen[a]  <= i_cell_pay[CW*a +: CW];
                r_size[a] <= i_cell_pay[3*CW + (CW-1)*a +: CW-1];
            end
        end
    end

    // Valid bits of the rotation pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
        end else if (en) begin
            r_a_v <= r_busy;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            r_f_v <= r_e_v;
        end
    end

    // Rotation about x, then y, then z: a product stage and a sum stage each.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_idx  <= r_cnt;
            r_a_x0   <= off_x;
            r_a_p[0] <= r_cos[0] * off_y;
            r_a_p[1] <= r_sin[0] * off_z;
            r_a_p[2] <= r_sin[0] * off_y;
            r_a_p[3] <= r_cos[0] * off_z;
            r_a_cy   <= r_cos[1];
            r_a_sy   <= r_sin[1];
            r_a_cz   <= r_cos[2];
            r_a_sz   <= r_sin[2];
            r_a_cen  <= r_cen;

            r_b_idx <= r_a_idx;
            r_b_x0  <= r_a_x0;
            r_b_y1  <= rnd({r_a_p[0][PRW-1], r_a_p[0]} - {r_a_p[1][PRW-1], r_a_p[1]});
            r_b_z1  <= rnd({r_a_p[2][PRW-1], r_a_p[2]} + {r_a_p[3][PRW-1], r_a_p[3]});
            r_b_cy  <= r_a_cy;
            r_b_sy  <= r_a_sy;
            r_b_cz  <= r_a_cz;
            r_b_sz  <= r_a_sz;
            r_b_cen <= r_a_cen;

            r_c_idx  <= r_b_idx;
            r_c_y1   <= r_b_y1;
            r_c_p[0] <= r_b_cy * r_b_x0;
            r_c_p[1] <= r_b_sy * r_b_z1;
            r_c_p[2] <= r_b_sy * r_b_x0;
            r_c_p[3] <= r_b_cy * r_b_z1;
            r_c_cz   <= r_b_cz;
            r_c_sz   <= r_b_sz;
            r_c_cen  <= r_b_cen;

            r_d_idx <= r_c_idx;
            r_d_y1  <= r_c_y1;
            r_d_x2  <= rnd({r_c_p[0][PRW-1], r_c_p[0]} + {r_c_p[1][PRW-1], r_c_p[1]});
            r_d_z2  <= rnd({r_c_p[3][PRW-1], r_c_p[3]} - {r_c_p[2][PRW-1], r_c_p[2]});
            r_d_cz  <= r_c_cz;
            r_d_sz  <= r_c_sz;
            r_d_cen <= r_c_cen;

            r_e_idx  <= r_d_idx;
            r_e_z2   <= r_d_z2;
            r_e_p[0] <= r_d_cz * r_d_x2;
            r_e_p[1] <= r_d_sz * r_d_y1;
            r_e_p[2] <= r_d_sz * r_d_x2;
            r_e_p[3] <= r_d_cz * r_d_y1;
            r_e_cen  <= r_d_cen;

            r_f_idx <= r_e_idx;
            r_f_x3  <= rnd({r_e_p[0][PRW-1], r_e_p[0]} - {r_e_p[1][PRW-1], r_e_p[1]});
            r_f_y3  <= rnd({r_e_p[2][PRW-1], r_e_p[2]} + {r_e_p[3][PRW-1], r_e_p[3]});
            r_f_z3  <= r_e_z2;
            r_f_cen <= r_e_cen;
        end
    end

    // Offset to corner, with saturation.
    assign n_x = fin(r_f_cen[0], r_f_x3);
    assign n_y = fin(r_f_cen[1], r_f_y3);
    assign n_z = fin(r_f_cen[2], r_f_z3);

    // Output register refills from the skid stage first, else from the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (!r_out_v || o_corner.ready) begin
            if (r_sk_v) begin
                r_out_v <= 1'b1;
                r_sk_v  <= 1'b0;
            end else begin
                r_out_v <= r_f_v;
            end
        end else if (en && r_f_v) begin
            r_sk_v <= 1'b1;
        end
        if (!r_out_v || o_corner.ready) begin
            if (r_sk_v) begin
                r_out_idx <= r_sk_idx;
                r_out_x   <= r_sk_x;
                r_out_y   <= r_sk_y;
                r_out_z   <= r_sk_z;
            end else begin
                r_out_idx <= r_f_idx;
                r_out_x   <= n_x;
                r_out_y   <= n_y;
                r_out_z   <= n_z;
            end
        end else if (en) begin
            r_sk_idx <= r_f_idx;
            r_sk_x   <= n_x;
            r_sk_y   <= n_y;
            r_sk_z   <= n_z;
        end
    end

    assign o_corner.valid        = r_out_v;
    assign o_corner.corner_index = r_out_idx;
    assign o_corner.corner_x     = $signed(r_out_x);
    assign o_corner.corner_y     = $signed(r_out_y);
    assign o_corner.corner_z     = $signed(r_out_z);
    assign o_corner.last_corner  = (r_out_idx == 3'd7);

    `OBCG_ASSERT_IMP(a_skid_behind_out, r_sk_v, r_out_v, "skid stage full while output empty")
    `OBCG_ASSERT_NXT(a_seq_continues, r_busy && en && r_cnt != 3'd7 && !take, r_busy,
                     "corner sequence ended early")
    `OBCG_ASSERT_NXT(a_issue_on_busy, r_busy && en, r_a_v, "busy sequencer issued no corner")
    `OBCG_ASSERT_IMP(a_take_when_free, take, !r_busy || r_cnt == 3'd7,
                     "box loaded over an unfinished one")

endmodule

@@ src/oriented_box_corner_generator.sv @@
// Top level of the oriented box corner generator: CORDIC cell row and corner pipeline.
//
//   channel    dir  carries                                         handshake
//   i_box      in   center, Euler angles and sizes of one box        valid/ready
//   o_corner   out  one corner: index, x, y, z, last-corner flag     valid/ready
//
// Each box holds the corner sequencer while its eight corners issue in order; the next
// box is taken as its last corner issues, so the corner issue slot sets the box rate.
// After a box is accepted, its first corner passes the 30 CORDIC cells, the sequencer
// load, six rotation stages and the output register, in that order.
// Reset is synchronous and active low; it clears the valid bits and the sequencer only.
// A stall on o_corner fills the skid stage, which then freezes the whole pipeline.
`include "oriented_box_corner_generator_assert.svh"
module oriented_box_corner_generator import obcg_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    obcg_box_if.sink      i_box,
    obcg_corner_if.source o_corner
);

    localparam int CW = COORD_WIDTH;
    localparam int AW = ANGLE_WIDTH;
    localparam int PW = 3 * CW + 3 * (CW - 1) + 3;

    logic                adv;
    logic                c_v   [0:CORDIC_STEPS];
    t_cvec [2:0]         c_vec [0:CORDIC_STEPS];
    logic [PW-1:0]       c_pay [0:CORDIC_STEPS];
    logic signed [AW-1:0] ang [3];
    logic [2:0]          flip;
    t_cvec [2:0]         vec0;

    assign ang[0] = i_box.angle_x;
    assign ang[1] = i_box.angle_y;
    assign ang[2] = i_box.angle_z;

    // Scale angles to Q30 and fold those beyond a quarter turn by half a turn.
    always_comb begin
        logic signed [Z_W-1:0] z;
        for (int a = 0; a < 3; a++) begin
            z = $signed({ang[a][AW-1], ang[a], {(33 - AW){1'b0}}});
            flip[a] = 1'b0;
            if (z > Q30_HALF_PI) begin
                z = z - Q30_PI;
                flip[a] = 1'b1;
            end else if (z < -Q30_HALF_PI) begin
                z = z + Q30_PI;
                flip[a] = 1'b1;
            end
            vec0[a].x = CORDIC_GAIN;
            vec0[a].y = '0;
            vec0[a].z = z;
        end
    end

    assign c_vec[0] = vec0;
    assign c_v[0]   = i_box.valid;
    assign c_pay[0] = {flip, i_box.size_z, i_box.size_y, i_box.size_x,
                       i_box.center_z, i_box.center_y, i_box.center_x};
    assign i_box.ready = adv;

    // Row of CORDIC cells, one iteration each.
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
        obcg_cordic_cell #(
            .STEP (k),
            .PW   (PW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_v     (c_v[k]),
            .i_vec   (c_vec[k]),
            .i_pay   (c_pay[k]),
            .o_v     (c_v[k+1]),
            .o_vec   (c_vec[k+1]),
            .o_pay   (c_pay[k+1])
        );
    end

    obcg_corner_pipe #(
        .CW (CW),
        .PW (PW)
    ) u_corner (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cell_v    (c_v[CORDIC_STEPS]),
        .i_cell_vec  (c_vec[CORDIC_STEPS]),
        .i_cell_pay  (c_pay[CORDIC_STEPS]),
        .o_chain_adv (adv),
        .o_corner    (o_corner)
    );

    `OBCG_ASSERT_NXT(a_box_enters_row, i_box.valid && i_box.ready, c_v[1],
                     "accepted box did not enter the first cell")
    `OBCG_ASSERT_NXT(a_row_holds, !adv && c_v[CORDIC_STEPS], c_v[CORDIC_STEPS],
                     "stalled row lost its last box")
    `OBCG_ASSERT_IMP(a_ready_stalls_on_full, c_v[CORDIC_STEPS] && !adv, !i_box.ready,
                     "box accepted while the row is stalled")

endmodule
